[rtl/crsf_pkg.sv]
// Shared types and constants for the CRSF channel decoder with failsafe.
// No dependencies.
package crsf_pkg;

   localparam logic [7:0]  SYNC_BYTE    = 8'hC8;
   localparam logic [7:0]  TYPE_RC      = 8'h16;
   localparam logic [7:0]  LEN_MIN      = 8'd5;
   localparam logic [7:0]  LEN_MAX      = 8'd32;
   localparam logic [10:0] MIDDLE_VALUE = 11'd992;
   localparam int          STORE_DEPTH  = 16;

   localparam logic        REQ_BYTE = 1'b0;
   localparam logic        REQ_TICK = 1'b1;

   localparam logic [1:0]  CSR_TIMEOUT = 2'd0;
   localparam logic [1:0]  CSR_REPEAT  = 2'd1;
   localparam logic [1:0]  CSR_SAFE    = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] REPEAT_RESET  = 16'd100;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  channel_index;
      logic [10:0] channel_value;
      logic        failsafe_flag;
      logic [31:0] time_ms;
      logic        last_of_run;
   } rsp_item_type;

   typedef struct packed {
      logic        safe;
      logic [31:0] stamp;
   } run_cmd_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  idx;
      logic [10:0] value;
   } store_wr_type;

   typedef struct packed {
      logic full;
      logic has_frame;
   } queue_status_type;

endpackage

[rtl/crsf_front.sv]
// Front end: frame parser, millisecond time base and failsafe timing.
// Issues run commands to the queue and channel writes to the store. Uses crsf_pkg.
module crsf_front #(
   parameter int FRAME_BYTES = 26,
   parameter int CHANNELS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  crsf_pkg::req_item_type item,
   input  logic [15:0]           timeout_ms,
   input  logic [15:0]           repeat_ms,
   output logic                  collecting,
   output logic                  push,
   output crsf_pkg::run_cmd_type push_cmd,
   output crsf_pkg::store_wr_type store_wr
);
   import crsf_pkg::*;

   localparam int POS_W  = $clog2(FRAME_BYTES);
   localparam int DONE_W = $clog2(CHANNELS + 1);

   logic              phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              len_ok_ff, len_ok_in;
   logic              type_ok_ff, type_ok_in;
   logic [18:0]       acc_ff, acc_in;
   logic [3:0]        fill_ff, fill_in;
   logic [DONE_W-1:0] done_ff, done_in;
   logic [31:0]       now_ff, now_in;
   logic [31:0]       last_frame_ff, last_frame_in;
   logic [31:0]       last_fs_ff, last_fs_in;
   logic              in_fs_ff, in_fs_in;
   logic              due_ff, due_in;

   logic [31:0] now_next;
   logic        fs_next;
   logic [18:0] acc_sum;
   logic [4:0]  fill_sum;

   assign collecting = phase_ff;
   assign now_next   = now_ff + 32'd1;
   assign fs_next    = in_fs_ff | ((now_next - last_frame_ff) > {16'd0, timeout_ms});
   assign acc_sum    = acc_ff | ({11'd0, item.rx_byte} << fill_ff);
   assign fill_sum   = {1'b0, fill_ff} + 5'd8;

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      len_ok_in     = len_ok_ff;
      type_ok_in    = type_ok_ff;
      acc_in        = acc_ff;
      fill_in       = fill_ff;
      done_in       = done_ff;
      now_in        = now_ff;
      last_frame_in = last_frame_ff;
      last_fs_in    = last_fs_ff;
      in_fs_in      = in_fs_ff;
      due_in        = due_ff;
      push          = 1'b0;
      push_cmd      = '{safe: 1'b0, stamp: now_ff};
      store_wr      = '{en: 1'b0, idx: 4'(done_ff), value: acc_sum[10:0]};
      if (accept) begin
         if (item.req_type == REQ_TICK) begin
            now_in   = now_next;
            in_fs_in = fs_next;
            if (fs_next && (due_ff || ((now_next - last_fs_ff) >= {16'd0, repeat_ms}))) begin
               last_fs_in = now_next;
               due_in     = 1'b0;
               push       = 1'b1;
               push_cmd   = '{safe: 1'b1, stamp: now_next};
            end
         end else if (!phase_ff) begin
            if (item.rx_byte == SYNC_BYTE) begin
               phase_in   = 1'b1;
               pos_in     = POS_W'(1);
               len_ok_in  = 1'b0;
               type_ok_in = 1'b0;
               acc_in     = '0;
               fill_in    = '0;
               done_in    = '0;
            end
         end else begin
            if (pos_ff == POS_W'(1)) begin
               len_ok_in = (item.rx_byte >= LEN_MIN) && (item.rx_byte <= LEN_MAX);
            end else if (pos_ff == POS_W'(2)) begin
               type_ok_in = (item.rx_byte == TYPE_RC);
            end else begin
               if (fill_sum >= 5'd11) begin
                  if ((done_ff < DONE_W'(CHANNELS)) && len_ok_ff && type_ok_ff) begin
                     store_wr.en = 1'b1;
                  end
                  if (done_ff < DONE_W'(CHANNELS)) begin
                     done_in = done_ff + DONE_W'(1);
                  end
                  acc_in  = acc_sum >> 11;
                  fill_in = 4'(fill_sum - 5'd11);
               end else begin
                  acc_in  = acc_sum;
                  fill_in = fill_sum[3:0];
               end
            end
            if (pos_ff >= POS_W'(FRAME_BYTES - 1)) begin
               phase_in = 1'b0;
               pos_in   = '0;
               acc_in   = '0;
               fill_in  = '0;
               if (len_ok_in && type_ok_in) begin
                  last_frame_in = now_ff;
                  in_fs_in      = 1'b0;
                  due_in        = 1'b1;
                  push          = 1'b1;
                  push_cmd      = '{safe: 1'b0, stamp: now_ff};
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 1'b0;
         pos_ff        <= '0;
         len_ok_ff     <= 1'b0;
         type_ok_ff    <= 1'b0;
         acc_ff        <= '0;
         fill_ff       <= '0;
         done_ff       <= '0;
         now_ff        <= '0;
         last_frame_ff <= '0;
         last_fs_ff    <= '0;
         in_fs_ff      <= 1'b1;
         due_ff        <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         len_ok_ff     <= len_ok_in;
         type_ok_ff    <= type_ok_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         done_ff       <= done_in;
         now_ff        <= now_in;
         last_frame_ff <= last_frame_in;
         last_fs_ff    <= last_fs_in;
         in_fs_ff      <= in_fs_in;
         due_ff        <= due_in;
      end
   end

endmodule

[rtl/crsf_queue.sv]
// Two-entry queue of run commands between front end and publisher.
// Uses crsf_pkg.
module crsf_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  crsf_pkg::run_cmd_type     push_cmd,
   input  logic                      pop,
   output logic                      head_valid,
   output crsf_pkg::run_cmd_type     head_cmd,
   output crsf_pkg::queue_status_type status
);
   import crsf_pkg::*;

   run_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign status.full = (count_ff == 2'd2);
   assign status.has_frame = (head_valid && !entry_ff[rd_ptr_ff].safe) ||
                             ((count_ff == 2'd2) && !entry_ff[~rd_ptr_ff].safe);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/crsf_emit.sv]
// Publisher: channel store and output register; turns run commands into
// one result transaction per channel. Uses crsf_pkg.
module crsf_emit #(
   parameter int CHANNELS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  crsf_pkg::store_wr_type store_wr,
   input  logic                   head_valid,
   input  crsf_pkg::run_cmd_type  head_cmd,
   input  logic [10:0]            safe_value,
   output logic                   pop,
   output logic                   frame_busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output crsf_pkg::rsp_item_type rsp_payload
);
   import crsf_pkg::*;

   logic [10:0]  store_ff [STORE_DEPTH];
   logic         active_ff, active_in;
   run_cmd_type  cmd_ff, cmd_in;
   logic [3:0]   idx_ff, idx_in;
   logic         valid_ff, valid_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         slot_free;
   logic         last_beat;

   assign slot_free  = !valid_ff || !rsp_stall;
   assign last_beat  = (idx_ff == 4'(CHANNELS - 1));
   assign pop        = !active_ff && head_valid;
   assign frame_busy = active_ff && !cmd_ff.safe;
   assign rsp_valid  = valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      active_in = active_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      rsp_in    = rsp_ff;
      if (pop) begin
         active_in = 1'b1;
         cmd_in    = head_cmd;
         idx_in    = '0;
      end
      if (slot_free) begin
         valid_in = active_ff;
         if (active_ff) begin
            rsp_in.channel_index = idx_ff;
            rsp_in.channel_value = cmd_ff.safe ? safe_value : store_ff[idx_ff];
            rsp_in.failsafe_flag = cmd_ff.safe;
            rsp_in.time_ms       = cmd_ff.stamp;
            rsp_in.last_of_run   = last_beat;
            idx_in               = idx_ff + 4'd1;
            if (last_beat) begin
               active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= MIDDLE_VALUE;
         end
      end else if (store_wr.en) begin
         store_ff[store_wr.idx] <= store_wr.value;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

[rtl/crsf_channel_decoder_failsafe_top.sv]
// Top level of the CRSF RC-channel decoder with failsafe publication.
// Holds the configuration registers; uses crsf_pkg, crsf_front, crsf_queue, crsf_emit.
//
// Request channel (req_*): one transaction is a received serial byte or a
// one millisecond tick. Bytes are parsed into frames; a frame with valid
// length and type publishes a run of CHANNELS result transactions. Ticks
// advance time and, in failsafe, publish runs of the safe value.
// Result channel (rsp_*): one transaction per channel, index 0 first,
// last_of_run set on the final one.
// A run command passes through the two-entry run queue, the publisher's
// command register and the output register before the first result of a run
// appears; after a run the publisher fetches the next command from the queue.
// Throughput: one request per cycle. Requests are stalled while the run
// queue is full, and requests (bytes and ticks) are stalled while a frame is
// being collected and an earlier frame's run is queued or still reading the
// channel store.
// Reset: configuration returns to its defaults, the store to 992, time to
// zero and the block starts in failsafe, so the first tick publishes a run.
// A stalled result holds; the queue fills and then the request side stalls.
module crsf_channel_decoder_failsafe_top #(
   parameter int FRAME_BYTES = 26,
   parameter int CHANNELS    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  crsf_pkg::req_item_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output crsf_pkg::rsp_item_type rsp_payload,
   input  logic                   csr_wen,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   import crsf_pkg::*;

   logic [15:0]      timeout_ff;
   logic [15:0]      repeat_ff;
   logic [10:0]      safe_ff;
   logic             accept;
   logic             collecting;
   logic             push;
   run_cmd_type      push_cmd;
   store_wr_type     store_wr;
   logic             pop;
   logic             head_valid;
   run_cmd_type      head_cmd;
   queue_status_type q_status;
   logic             frame_busy;

   assign req_stall = q_status.full || (collecting && (q_status.has_frame || frame_busy));
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         repeat_ff  <= REPEAT_RESET;
         safe_ff    <= MIDDLE_VALUE;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_REPEAT:  repeat_ff  <= csr_wdata;
            CSR_SAFE:    safe_ff    <= csr_wdata[10:0];
            default:     ;
         endcase
      end
   end

   crsf_front #(
      .FRAME_BYTES(FRAME_BYTES),
      .CHANNELS   (CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .item       (req_payload),
      .timeout_ms (timeout_ff),
      .repeat_ms  (repeat_ff),
      .collecting (collecting),
      .push       (push),
      .push_cmd   (push_cmd),
      .store_wr   (store_wr)
   );

   crsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .status     (q_status)
   );

   crsf_emit #(
      .CHANNELS(CHANNELS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .store_wr    (store_wr),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .safe_value  (safe_ff),
      .pop         (pop),
      .frame_busy  (frame_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[rtl/crsf_checker.sv]
// Port-level checks for the CRSF decoder top level, attached by bind.
// Uses crsf_pkg.
module crsf_checker #(
   parameter int CHANNELS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input crsf_pkg::rsp_item_type rsp_payload
);
   import crsf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_of_run == (rsp_payload.channel_index == 4'(CHANNELS - 1))))
      else $error("last_of_run does not match final channel");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last_of_run |=>
         rsp_valid &&
         (rsp_payload.channel_index == $past(rsp_payload.channel_index) + 4'd1) &&
         (rsp_payload.time_ms == $past(rsp_payload.time_ms)) &&
         (rsp_payload.failsafe_flag == $past(rsp_payload.failsafe_flag)))
      else $error("run broken or out of order");

endmodule

bind crsf_channel_decoder_failsafe_top crsf_checker #(
   .CHANNELS(CHANNELS)
) u_crsf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
